FILE: hw/rtl/esa_pkg.sv
// Package with the beat types, command codes and step tables of the setpoint adjuster.
`timescale 1ns / 1ps
`default_nettype none
package esa_pkg;

	localparam int VoltW  = 25;
	localparam int CurrW  = 23;
	localparam int EntryW = 32;
	localparam int ClampW = EntryW + 1;

	localparam logic [2:0] CMD_ENCODER   = 3'd0;
	localparam logic [2:0] CMD_STEP_UP   = 3'd1;
	localparam logic [2:0] CMD_STEP_DOWN = 3'd2;
	localparam logic [2:0] CMD_SEL_TGT   = 3'd3;
	localparam logic [2:0] CMD_SEL_CHAN  = 3'd4;
	localparam logic [2:0] CMD_ENTRY     = 3'd5;

	localparam logic [1:0] TGT_VOLT     = 2'd0;
	localparam logic [1:0] TGT_CURR_POS = 2'd1;
	localparam logic [1:0] TGT_CURR_NEG = 2'd2;
	localparam logic [1:0] TGT_UNUSED   = 2'd3;

	localparam logic [1:0] UPD_NONE     = 2'd0;
	localparam logic [1:0] UPD_VOLT     = 2'd1;
	localparam logic [1:0] UPD_CURR_POS = 2'd2;
	localparam logic [1:0] UPD_CURR_NEG = 2'd3;

	localparam logic [2:0] STEP_MAX = 3'd4;

	localparam logic REG_VOLT_MAX = 1'b0;
	localparam logic REG_CURR_MAX = 1'b1;

	localparam logic [VoltW-1:0] VOLT_MAX_RESET = 25'd25000000;
	localparam logic [CurrW-1:0] CURR_MAX_RESET = 23'd5000000;
	localparam logic [VoltW-1:0] VOLT_RESET     = 25'd20000;
	localparam logic [CurrW-1:0] CURR_RESET     = 23'd1;
	localparam logic [VoltW-1:0] VOLT_LOW_ENC   = 25'd20000;
	localparam logic [VoltW-1:0] VOLT_LOW_ENTRY = 25'd10000;
	localparam logic [CurrW-1:0] CURR_LOW       = 23'd1;

	typedef struct packed {
		logic [2:0]        command;
		logic              clk_level;
		logic              dt_level;
		logic [1:0]        target_choice;
		logic              channel_choice;
		logic [EntryW-1:0] entry_value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       updated;
		logic [VoltW-1:0] volt_out;
		logic [CurrW-1:0] curr_pos_out;
		logic [CurrW-1:0] curr_neg_out;
		logic [2:0]       step_out;
		logic [1:0]       target_out;
		logic             channel_out;
	} out_beat_t;

	// Decade steps in microvolts.
	function automatic logic [23:0] volt_step(input logic [2:0] idx);
		logic [23:0] s;
		case (idx)
			3'd0:    s = 24'd1000;
			3'd1:    s = 24'd10000;
			3'd2:    s = 24'd100000;
			3'd3:    s = 24'd1000000;
			default: s = 24'd10000000;
		endcase
		return s;
	endfunction

	// Decade steps in microamps.
	function automatic logic [19:0] curr_step(input logic [2:0] idx);
		logic [19:0] s;
		case (idx)
			3'd0:    s = 20'd100;
			3'd1:    s = 20'd1000;
			3'd2:    s = 20'd10000;
			3'd3:    s = 20'd100000;
			default: s = 20'd1000000;
		endcase
		return s;
	endfunction

	// The low limit wins first, so crossed limits still give a defined value.
	function automatic logic [VoltW-1:0] volt_clamp(input logic signed [ClampW-1:0] v,
			input logic [VoltW-1:0] lo, input logic [VoltW-1:0] hi);
		logic [VoltW-1:0] r;
		if (v < $signed({{(ClampW-VoltW){1'b0}}, lo})) begin
			r = lo;
		end else if (v > $signed({{(ClampW-VoltW){1'b0}}, hi})) begin
			r = hi;
		end else begin
			r = v[VoltW-1:0];
		end
		return r;
	endfunction

	function automatic logic [CurrW-1:0] curr_clamp(input logic signed [ClampW-1:0] v,
			input logic [CurrW-1:0] lo, input logic [CurrW-1:0] hi);
		logic [CurrW-1:0] r;
		if (v < $signed({{(ClampW-CurrW){1'b0}}, lo})) begin
			r = lo;
		end else if (v > $signed({{(ClampW-CurrW){1'b0}}, hi})) begin
			r = hi;
		end else begin
			r = v[CurrW-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/encoder_setpoint_adjuster.sv
// Top level of the front-panel setpoint adjuster: input register, update logic, result register.
// A result is registered in the result register when its command beat advances from the input register.
// Throughput: one command per cycle while no finished result is held by out_stall; the setpoint
// registers feed the combinational add and clamp between the input register and the result register.
// While a finished result waits on out_stall, the input register takes one more beat and then stalls.
// Reset (arst_n low, asynchronous): setpoints 20 mV, 1 uA, 1 uA, step index, target,
// channel and encoder phase zero, limits 25 V and 5 A, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
module encoder_setpoint_adjuster (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  esa_pkg::in_beat_t      in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output esa_pkg::out_beat_t     out_data,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [2:0]             paddr,
	input  wire  [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic                          valid_s1;
	esa_pkg::in_beat_t             beat_s1;
	logic                          advance;

	logic [esa_pkg::VoltW-1:0]     volt_max_q;
	logic [esa_pkg::CurrW-1:0]     curr_max_q;
	logic [esa_pkg::VoltW-1:0]     volt_q;
	logic [esa_pkg::CurrW-1:0]     cpos_q;
	logic [esa_pkg::CurrW-1:0]     cneg_q;
	logic [2:0]                    step_q;
	logic [1:0]                    tgt_q;
	logic                          chan_q;
	logic                          phase_q;

	logic [esa_pkg::VoltW-1:0]     volt_d;
	logic [esa_pkg::CurrW-1:0]     cpos_d;
	logic [esa_pkg::CurrW-1:0]     cneg_d;
	logic [2:0]                    step_d;
	logic [1:0]                    tgt_d;
	logic                          chan_d;
	logic                          phase_d;
	logic [1:0]                    upd_d;

	logic                          out_valid_q;
	esa_pkg::out_beat_t            out_q;

	logic [2:0]                    si;
	logic                          up;
	logic [23:0]                   vstep;
	logic [19:0]                   cstep;
	logic signed [esa_pkg::ClampW-1:0] v_base, p_base, n_base;
	logic signed [esa_pkg::ClampW-1:0] v_sum, p_sum, n_sum, entry_s;
	logic                          cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_max_q <= esa_pkg::VOLT_MAX_RESET;
			curr_max_q <= esa_pkg::CURR_MAX_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				esa_pkg::REG_VOLT_MAX: volt_max_q <= pwdata[esa_pkg::VoltW-1:0];
				esa_pkg::REG_CURR_MAX: curr_max_q <= pwdata[esa_pkg::CurrW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			esa_pkg::REG_VOLT_MAX: prdata = {{(32-esa_pkg::VoltW){1'b0}}, volt_max_q};
			esa_pkg::REG_CURR_MAX: prdata = {{(32-esa_pkg::CurrW){1'b0}}, curr_max_q};
			default:               prdata = 32'd0;
		endcase
	end

	// ---------------- handshake ----------------
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_data;
		end
	end

	// ---------------- update logic ----------------
	assign si    = (step_q > esa_pkg::STEP_MAX) ? esa_pkg::STEP_MAX : step_q;
	assign up    = beat_s1.dt_level != beat_s1.clk_level;
	assign vstep = esa_pkg::volt_step(si);
	assign cstep = esa_pkg::curr_step(si);

	assign v_base  = $signed({{(esa_pkg::ClampW-esa_pkg::VoltW){1'b0}}, volt_q});
	assign p_base  = $signed({{(esa_pkg::ClampW-esa_pkg::CurrW){1'b0}}, cpos_q});
	assign n_base  = $signed({{(esa_pkg::ClampW-esa_pkg::CurrW){1'b0}}, cneg_q});
	assign entry_s = $signed({1'b0, beat_s1.entry_value});

	// Only the selected setpoint of the first channel moves; all three are clamped.
	always_comb begin
		logic signed [esa_pkg::ClampW-1:0] vs, cs;
		vs = $signed({{(esa_pkg::ClampW-24){1'b0}}, vstep});
		cs = $signed({{(esa_pkg::ClampW-20){1'b0}}, cstep});
		v_sum = v_base;
		p_sum = p_base;
		n_sum = n_base;
		if (!chan_q) begin
			case (tgt_q)
				esa_pkg::TGT_VOLT:     v_sum = up ? v_base + vs : v_base - vs;
				esa_pkg::TGT_CURR_POS: p_sum = up ? p_base + cs : p_base - cs;
				esa_pkg::TGT_CURR_NEG: n_sum = up ? n_base + cs : n_base - cs;
				default: ;
			endcase
		end
	end

	always_comb begin
		volt_d  = volt_q;
		cpos_d  = cpos_q;
		cneg_d  = cneg_q;
		step_d  = step_q;
		tgt_d   = tgt_q;
		chan_d  = chan_q;
		phase_d = phase_q;
		upd_d   = esa_pkg::UPD_NONE;
		case (beat_s1.command)
			esa_pkg::CMD_ENCODER: begin
				phase_d = !phase_q;
				// An encoder beat that finds the phase at one ends a detent, brings the phase back to zero and moves the setpoint.
				if (phase_q) begin
					volt_d = esa_pkg::volt_clamp(v_sum, esa_pkg::VOLT_LOW_ENC, volt_max_q);
					cpos_d = esa_pkg::curr_clamp(p_sum, esa_pkg::CURR_LOW, curr_max_q);
					cneg_d = esa_pkg::curr_clamp(n_sum, esa_pkg::CURR_LOW, curr_max_q);
					if (!chan_q) begin
						case (tgt_q)
							esa_pkg::TGT_VOLT:     upd_d = esa_pkg::UPD_VOLT;
							esa_pkg::TGT_CURR_POS: upd_d = esa_pkg::UPD_CURR_POS;
							esa_pkg::TGT_CURR_NEG: upd_d = esa_pkg::UPD_CURR_NEG;
							default:               upd_d = esa_pkg::UPD_NONE;
						endcase
					end
				end
			end
			esa_pkg::CMD_STEP_UP: begin
				step_d = (step_q < esa_pkg::STEP_MAX) ? step_q + 3'd1 : esa_pkg::STEP_MAX;
			end
			esa_pkg::CMD_STEP_DOWN: begin
				if (step_q != 3'd0) begin
					step_d = step_q - 3'd1;
				end
			end
			esa_pkg::CMD_SEL_TGT: begin
				if (beat_s1.target_choice != esa_pkg::TGT_UNUSED) begin
					tgt_d = beat_s1.target_choice;
				end
			end
			esa_pkg::CMD_SEL_CHAN: begin
				chan_d = beat_s1.channel_choice;
			end
			esa_pkg::CMD_ENTRY: begin
				if (!chan_q) begin
					case (tgt_q)
						esa_pkg::TGT_VOLT: begin
							volt_d = esa_pkg::volt_clamp(entry_s, esa_pkg::VOLT_LOW_ENTRY,
								volt_max_q);
							upd_d  = esa_pkg::UPD_VOLT;
						end
						esa_pkg::TGT_CURR_POS: begin
							cpos_d = esa_pkg::curr_clamp(entry_s, esa_pkg::CURR_LOW, curr_max_q);
							upd_d  = esa_pkg::UPD_CURR_POS;
						end
						esa_pkg::TGT_CURR_NEG: begin
							cneg_d = esa_pkg::curr_clamp(entry_s, esa_pkg::CURR_LOW, curr_max_q);
							upd_d  = esa_pkg::UPD_CURR_NEG;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// ---------------- state and result registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_q  <= esa_pkg::VOLT_RESET;
			cpos_q  <= esa_pkg::CURR_RESET;
			cneg_q  <= esa_pkg::CURR_RESET;
			step_q  <= 3'd0;
			tgt_q   <= esa_pkg::TGT_VOLT;
			chan_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (advance) begin
			volt_q  <= volt_d;
			cpos_q  <= cpos_d;
			cneg_q  <= cneg_d;
			step_q  <= step_d;
			tgt_q   <= tgt_d;
			chan_q  <= chan_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.updated      <= upd_d;
			out_q.volt_out     <= volt_d;
			out_q.curr_pos_out <= cpos_d;
			out_q.curr_neg_out <= cneg_d;
			out_q.step_out     <= step_d;
			out_q.target_out   <= tgt_d;
			out_q.channel_out  <= chan_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= esa_pkg::STEP_MAX)
		else $error("step index above its maximum");

	a_tgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q != esa_pkg::TGT_UNUSED)
		else $error("unused target code selected");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced beat produced no result");

	a_phase_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && beat_s1.command == esa_pkg::CMD_ENCODER) |=> (phase_q != $past(phase_q)))
		else $error("encoder edge did not toggle the phase");

	a_chan1_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && chan_q) |=> (out_data.updated == esa_pkg::UPD_NONE))
		else $error("second channel reported a setpoint update");

endmodule
`default_nettype wire
